/* rtl/ssl_pkg.sv */
// Shared types and constants for the shifting sequential list unit.
// Used by ssl_cell, shifting_sequential_list_unit and ssl_chk; no dependencies.
package ssl_pkg;

    localparam int CAP      = 64;
    localparam int CW       = $clog2(CAP + 1);
    localparam int IW       = $clog2(CAP);
    localparam int KW       = 32;
    localparam int PW       = 32;
    localparam int OPW      = 3;
    localparam int POSW     = 7;
    localparam int CNTW     = 7;
    localparam int PCW      = (CW > POSW) ? CW : POSW;
    localparam int IN_FW    = OPW + KW + PW + POSW;
    localparam int IN_TDW   = ((IN_FW + 7) / 8) * 8;
    localparam int OUT_FW   = 1 + KW + PW + CNTW + 1 + 1;
    localparam int OUT_TDW  = ((OUT_FW + 7) / 8) * 8;

    typedef enum logic [OPW-1:0] {
        OP_INS_END   = 3'd0,
        OP_INS_START = 3'd1,
        OP_INS_POS   = 3'd2,
        OP_REM_END   = 3'd3,
        OP_REM_START = 3'd4,
        OP_REM_POS   = 3'd5,
        OP_REM_KEY   = 3'd6,
        OP_CLEAR     = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        M_NOP = 2'd0,
        M_INS = 2'd1,
        M_REM = 2'd2
    } t_mode;

    typedef struct packed {
        logic signed [KW-1:0] key;
        logic [PW-1:0]        payload;
    } t_rec;

    // Request token that walks the cell row, one cell per cycle.
    typedef struct packed {
        logic                 valid;
        t_mode                mode;
        logic                 bykey;
        logic                 okp;    // NOP: 1 = clear, 0 = rejected
        logic                 found;
        logic [CW-1:0]        pos;
        logic [CW-1:0]        cnt;    // count when the request started
        logic signed [KW-1:0] key;
        t_rec                 rec;    // carried record (insert ripple / removed record)
    } t_tok;

endpackage

/* rtl/shifting_sequential_list_unit.sv */
// Top level of the shifting sequential list: request decode, cell row, result stage.
// Depends on ssl_pkg and ssl_cell.
//
// An ordered list of up to CAP key/payload records held in a row of CAP cells.
// Each request word becomes a token that walks the whole row, one cell per
// cycle, shifting records to open or close a gap and searching keys as it
// passes. One request is in flight at a time: the request register, the token
// register of each cell, a result register and the output register lie in turn,
// and the next request is taken as soon as the result sits in the output register,
// even if the consumer has not taken it yet. The row length sets the latency.
module shifting_sequential_list_unit
    import ssl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // [2:0] operation, [34:3] item_key, [66:35] item_payload, [73:67] position
    input  logic [IN_TDW-1:0]  s_axis_tdata,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [0] ok, [32:1] out_key, [64:33] out_payload, [71:65] count,
    // [72] is_empty, [73] is_full
    output logic [OUT_TDW-1:0] m_axis_tdata
);

    t_tok               tok [0:CAP];
    t_rec               rec [0:CAP-1];

    logic               r_busy;
    logic [CW-1:0]      r_cnt;
    t_tok               r_inj;
    t_tok               n_inj;
    logic               r_fin_v;
    logic [OUT_TDW-1:0] r_fin;
    logic [OUT_TDW-1:0] n_fin;
    logic [CW-1:0]      n_cnt;
    logic               r_ov;
    logic [OUT_TDW-1:0] r_od;

    logic               acc;
    logic               out_free;
    t_op                in_op;
    logic [POSW-1:0]    in_pos;
    logic [PCW-1:0]     pos_w;
    logic [PCW-1:0]     cnt_w;
    logic               full;
    logic               empty;
    t_tok               ex;
    logic               ex_ok;
    logic               ex_rem;
    t_rec               ex_rec;

    assign s_axis_tready = !r_busy;
    assign acc           = s_axis_tvalid && !r_busy;
    assign out_free      = !r_ov || m_axis_tready;

    // request decode
    always_comb begin
        in_op       = t_op'(s_axis_tdata[OPW-1:0]);
        in_pos      = s_axis_tdata[OPW+KW+PW +: POSW];
        pos_w       = PCW'(in_pos);
        cnt_w       = PCW'(r_cnt);
        full        = r_cnt == CW'(CAP);
        empty       = r_cnt == '0;
        n_inj       = '0;
        n_inj.valid = acc;
        n_inj.mode  = M_NOP;
        n_inj.cnt   = r_cnt;
        n_inj.key   = s_axis_tdata[OPW +: KW];
        n_inj.rec.key     = s_axis_tdata[OPW +: KW];
        n_inj.rec.payload = s_axis_tdata[OPW+KW +: PW];
        case (in_op)
            OP_INS_END: begin
                if (!full) begin
                    n_inj.mode = M_INS;
                    n_inj.pos  = r_cnt;
                end
            end
            OP_INS_START: begin
                if (!full) begin
                    n_inj.mode = M_INS;
                    n_inj.pos  = '0;
                end
            end
            OP_INS_POS: begin
                if (!full && (pos_w <= cnt_w)) begin
                    n_inj.mode = M_INS;
                    n_inj.pos  = CW'(in_pos);
                end
            end
            OP_REM_END: begin
                if (!empty) begin
                    n_inj.mode = M_REM;
                    n_inj.pos  = r_cnt - CW'(1);
                end
            end
            OP_REM_START: begin
                if (!empty) begin
                    n_inj.mode = M_REM;
                    n_inj.pos  = '0;
                end
            end
            OP_REM_POS: begin
                if (pos_w < cnt_w) begin
                    n_inj.mode = M_REM;
                    n_inj.pos  = CW'(in_pos);
                end
            end
            OP_REM_KEY: begin
                n_inj.mode  = M_REM;
                n_inj.bykey = 1'b1;
            end
            OP_CLEAR: begin
                n_inj.okp = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign tok[0] = r_inj;

    genvar g;
    generate
        for (g = 0; g < CAP; g++) begin : g_cell
            ssl_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_index (IW'(g)),
                .i_tok   (tok[g]),
                .i_right ((g == CAP - 1) ? rec[g] : rec[(g + 1) % CAP]),
                .o_tok   (tok[g + 1]),
                .o_rec   (rec[g])
            );
        end
    endgenerate

    // result of the token leaving the row
    always_comb begin
        ex     = tok[CAP];
        ex_rem = (ex.mode == M_REM) && ex.found;
        ex_rec = ex_rem ? ex.rec : '0;
        n_cnt  = ex.cnt;
        case (ex.mode)
            M_INS: begin
                ex_ok = 1'b1;
                n_cnt = ex.cnt + CW'(1);
            end
            M_REM: begin
                ex_ok = ex.found;
                if (ex.found) begin
                    n_cnt = ex.cnt - CW'(1);
                end
            end
            default: begin
                ex_ok = ex.okp;
                if (ex.okp) begin
                    n_cnt = '0;
                end
            end
        endcase
        n_fin = OUT_TDW'({n_cnt == CW'(CAP), n_cnt == '0, CNTW'(n_cnt),
                          ex_rec.payload, ex_rec.key, ex_ok});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_cnt   <= '0;
            r_inj   <= '0;
            r_fin_v <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_inj <= n_inj;
            if (acc) begin
                r_busy <= 1'b1;
            end else if (r_fin_v && out_free) begin
                r_busy <= 1'b0;
            end
            if (ex.valid) begin
                r_cnt   <= n_cnt;
                r_fin_v <= 1'b1;
            end else if (out_free) begin
                r_fin_v <= 1'b0;
            end
            if (out_free) begin
                r_ov <= r_fin_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ex.valid) begin
            r_fin <= n_fin;
        end
        if (out_free && r_fin_v) begin
            r_od <= r_fin;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;

endmodule

/* rtl/ssl_cell.sv */
// One storage cell of the shifting list: holds a record and a token stage.
// Depends on ssl_pkg.
module ssl_cell
    import ssl_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [IW-1:0] i_index,
    input  t_tok          i_tok,
    input  t_rec          i_right,
    output t_tok          o_tok,
    output t_rec          o_rec
);

    t_rec          r_rec;
    t_rec          n_rec;
    t_tok          r_tok;
    t_tok          n_tok;
    logic [CW-1:0] idx;
    logic          in_rng;
    logic          ins_act;
    logic          hit;

    always_comb begin
        idx     = CW'(i_index);
        in_rng  = idx < i_tok.cnt;
        ins_act = (idx >= i_tok.pos) && (idx <= i_tok.cnt);
        hit     = !i_tok.found && in_rng &&
                  (i_tok.bykey ? (r_rec.key == i_tok.key) : (idx == i_tok.pos));
        n_rec   = r_rec;
        n_tok   = i_tok;
        if (i_tok.valid) begin
            case (i_tok.mode)
                M_INS: begin
                    if (ins_act) begin
                        n_rec     = i_tok.rec;
                        n_tok.rec = r_rec;
                    end
                end
                M_REM: begin
                    if (hit) begin
                        n_tok.rec   = r_rec;
                        n_tok.found = 1'b1;
                    end
                    if ((hit || i_tok.found) && in_rng) begin
                        n_rec = i_right;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;
    assign o_rec = r_rec;

endmodule

/* rtl/ssl_chk.sv */
// Port-level checker for shifting_sequential_list_unit, bound to the top level.
// Depends on ssl_pkg.
module ssl_chk
    import ssl_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic [IN_TDW-1:0]  s_axis_tdata,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [OUT_TDW-1:0] m_axis_tdata
);

    logic [CNTW-1:0] o_cnt;
    assign o_cnt = m_axis_tdata[1+KW+PW +: CNTW];

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while another is in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result word changed");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((o_cnt <= CNTW'(CAP)) &&
                           (m_axis_tdata[1+KW+PW+CNTW] == (o_cnt == '0)) &&
                           (m_axis_tdata[2+KW+PW+CNTW] == (o_cnt == CNTW'(CAP)))))
        else $error("count and empty/full flags disagree");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[KW+PW:1] == '0))
        else $error("rejected request returned a record");

endmodule

bind shifting_sequential_list_unit ssl_chk u_ssl_chk (.*);
